// ===== hw/rtl/ftr_pkg.sv =====
// ----------------------------------------------------------------------------
// ftr_pkg: shared types and constants for the frequency to RGB block
// Widths of the divider chains, the band codes and the word that moves
// from cell to cell.
// ----------------------------------------------------------------------------
package ftr_pkg;

    // input frequency width in bits (20 to 32)
    localparam int FREQ_WIDTH = 20;

    // wavelength fraction bits (units of 1/16 nm)
    localparam int WL_FRAC = 4;

    // dividend / quotient register width of every divider cell
    localparam int QUO_W = 33;

    // 16 * speed of light in m/s: wavelength numerator in 1/16 nm * GHz
    localparam logic [QUO_W-1:0] WL_DIVIDEND = QUO_W'(64'd299792458 << WL_FRAC);

    // one quotient bit per cell in the wavelength chain
    localparam int WL_STEPS = QUO_W;

    // channel level and ramp distance widths
    localparam int LEVEL_W = 8;
    localparam int DIST_W  = 11;

    // ramp product max_level * distance, and the ramp chain length
    localparam int PROD_W     = LEVEL_W + DIST_W;
    localparam int RAMP_STEPS = PROD_W;

    // color band of a wavelength
    typedef enum logic [2:0] {
        BAND_NONE,
        BAND_VIOLET,   // 380..440: red ramps down, blue full
        BAND_BLUE,     // 440..490: green ramps up, blue full
        BAND_CYAN,     // 490..510: green full, blue ramps down
        BAND_GREEN,    // 510..580: red ramps up, green full
        BAND_YELLOW,   // 580..645: red full, green ramps down
        BAND_RED       // 645..781: red full
    } band_t;

    // side information carried along with each word
    typedef struct packed {
        logic  zero;
        band_t band;
    } tag_t;

    // one word between divider cells
    typedef struct packed {
        logic                  valid;
        tag_t                  tag;
        logic [FREQ_WIDTH-1:0] rem;
        logic [FREQ_WIDTH-1:0] dvs;
        logic [QUO_W-1:0]      quo;
    } cell_t;

endpackage

// ===== hw/rtl/frequency_to_rgb_top.sv =====
// ----------------------------------------------------------------------------
// frequency_to_rgb_top: light frequency to RGB color
// Frequency in GHz in, red/green/blue levels out, one word per clock while the output is not held.
// ----------------------------------------------------------------------------
// Usage: takes one word per clock and returns one per clock while the output
// word is not held. It is built from two rows of restoring divider cells, one
// quotient bit per cell, for a 33-bit quotient and a 19-bit ramp product: the
// first divides 16 * c by the frequency to get the wavelength in 1/16 nm, the
// second divides max_level * distance by the ramp span. When the output word
// is held, the whole pipeline holds and s_ready drops. A zero frequency or a
// wavelength outside 380..781 nm gives black. max_level (reset 255) is written
// through cfg_wr_en / cfg_wr_data; the user must write it only while the block
// is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module frequency_to_rgb_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ftr_pkg::LEVEL_W-1:0]    cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ftr_pkg::FREQ_WIDTH-1:0] s_frequency_ghz,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ftr_pkg::LEVEL_W-1:0]    m_red,
    output logic [ftr_pkg::LEVEL_W-1:0]    m_green,
    output logic [ftr_pkg::LEVEL_W-1:0]    m_blue
);

    localparam int LW = ftr_pkg::LEVEL_W;

    logic              adv;
    logic [LW-1:0]     max_level_reg;
    ftr_pkg::cell_t    wl_chain   [0:ftr_pkg::WL_STEPS];
    ftr_pkg::cell_t    ramp_chain [0:ftr_pkg::RAMP_STEPS];
    ftr_pkg::cell_t    last;
    logic [LW-1:0]     level;
    logic [LW-1:0]     red_next;
    logic [LW-1:0]     green_next;
    logic [LW-1:0]     blue_next;
    logic              out_valid_reg;
    logic [LW-1:0]     red_reg;
    logic [LW-1:0]     green_reg;
    logic [LW-1:0]     blue_reg;

    // pipeline moves whenever the output register is free or drained
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_level_reg <= LW'(255);
        end else if (cfg_wr_en) begin
            max_level_reg <= cfg_wr_data;
        end
    end

    // wavelength divider input: constant dividend, frequency as divisor
    assign wl_chain[0] = '{valid: s_valid,
                           tag:   '{zero: (s_frequency_ghz == '0),
                                    band: ftr_pkg::BAND_NONE},
                           rem:   '0,
                           dvs:   s_frequency_ghz,
                           quo:   ftr_pkg::WL_DIVIDEND};

    // wavelength divider row
    for (genvar i = 0; i < ftr_pkg::WL_STEPS; i++) begin : g_wl
        ftr_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .cell_in  (wl_chain[i]),
            .cell_out (wl_chain[i+1])
        );
    end

    // band lookup and ramp product
    ftr_band u_band (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .max_level (max_level_reg),
        .wl_in     (wl_chain[ftr_pkg::WL_STEPS]),
        .ramp_out  (ramp_chain[0])
    );

    // ramp divider row
    for (genvar i = 0; i < ftr_pkg::RAMP_STEPS; i++) begin : g_ramp
        ftr_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .cell_in  (ramp_chain[i]),
            .cell_out (ramp_chain[i+1])
        );
    end

    // channel mix per band
    always_comb begin
        last       = ramp_chain[ftr_pkg::RAMP_STEPS];
        level      = last.quo[LW-1:0];
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        case (last.tag.band)
            ftr_pkg::BAND_VIOLET: begin
                red_next  = level;
                blue_next = max_level_reg;
            end
            ftr_pkg::BAND_BLUE: begin
                green_next = level;
                blue_next  = max_level_reg;
            end
            ftr_pkg::BAND_CYAN: begin
                green_next = max_level_reg;
                blue_next  = level;
            end
            ftr_pkg::BAND_GREEN: begin
                red_next   = level;
                green_next = max_level_reg;
            end
            ftr_pkg::BAND_YELLOW: begin
                red_next   = max_level_reg;
                green_next = level;
            end
            ftr_pkg::BAND_RED: begin
                red_next = max_level_reg;
            end
            default: begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
        endcase
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

endmodule

// ===== hw/rtl/ftr_div_cell.sv =====
// ----------------------------------------------------------------------------
// ftr_div_cell: one restoring division step
// Shifts the next dividend bit out of the top of the quotient register into
// the partial remainder, subtracts the divisor when it fits and shifts the
// quotient bit in at the bottom. Registered; moves when enabled.
// ----------------------------------------------------------------------------
module ftr_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  ftr_pkg::cell_t cell_in,
    output ftr_pkg::cell_t cell_out
);

    logic [ftr_pkg::FREQ_WIDTH:0]   trial;
    logic                           fits;
    logic [ftr_pkg::FREQ_WIDTH:0]   diff;
    ftr_pkg::cell_t                 step;
    logic                           valid_reg;
    ftr_pkg::tag_t                  tag_reg;
    logic [ftr_pkg::FREQ_WIDTH-1:0] rem_reg;
    logic [ftr_pkg::FREQ_WIDTH-1:0] dvs_reg;
    logic [ftr_pkg::QUO_W-1:0]      quo_reg;

    // trial subtract
    always_comb begin
        trial = {cell_in.rem, cell_in.quo[ftr_pkg::QUO_W-1]};
        fits  = (trial >= {1'b0, cell_in.dvs});
        diff  = trial - {1'b0, cell_in.dvs};
        step  = cell_in;
        step.rem = fits ? diff[ftr_pkg::FREQ_WIDTH-1:0]
                        : trial[ftr_pkg::FREQ_WIDTH-1:0];
        step.quo = {cell_in.quo[ftr_pkg::QUO_W-2:0], fits};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= cell_in.valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg <= step.tag;
            rem_reg <= step.rem;
            dvs_reg <= step.dvs;
            quo_reg <= step.quo;
        end
    end

    assign cell_out = '{valid: valid_reg, tag: tag_reg, rem: rem_reg,
                        dvs: dvs_reg, quo: quo_reg};

endmodule

// ===== hw/rtl/ftr_band.sv =====
// ----------------------------------------------------------------------------
// ftr_band: band lookup and ramp product
// Stage one sorts the wavelength into a band and forms the ramp distance and
// span. Stage two multiplies the distance by max_level and loads the product
// as dividend, with the span as divisor, for the ramp divider chain.
// ----------------------------------------------------------------------------
module ftr_band (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [ftr_pkg::LEVEL_W-1:0]   max_level,
    input  ftr_pkg::cell_t                wl_in,
    output ftr_pkg::cell_t                ramp_out
);

    localparam int CW = ftr_pkg::QUO_W;
    localparam int SW = 14;   // enough for every bound below 781 nm

    localparam logic [CW-1:0] WL_380 = CW'(380 << ftr_pkg::WL_FRAC);
    localparam logic [CW-1:0] WL_440 = CW'(440 << ftr_pkg::WL_FRAC);
    localparam logic [CW-1:0] WL_490 = CW'(490 << ftr_pkg::WL_FRAC);
    localparam logic [CW-1:0] WL_510 = CW'(510 << ftr_pkg::WL_FRAC);
    localparam logic [CW-1:0] WL_580 = CW'(580 << ftr_pkg::WL_FRAC);
    localparam logic [CW-1:0] WL_645 = CW'(645 << ftr_pkg::WL_FRAC);
    localparam logic [CW-1:0] WL_781 = CW'(781 << ftr_pkg::WL_FRAC);

    localparam logic [SW-1:0] S_440 = WL_440[SW-1:0];
    localparam logic [SW-1:0] S_510 = WL_510[SW-1:0];
    localparam logic [SW-1:0] S_645 = WL_645[SW-1:0];

    localparam int DW = ftr_pkg::DIST_W;
    localparam int FW = ftr_pkg::FREQ_WIDTH;
    localparam int PW = ftr_pkg::PROD_W;

    localparam logic [DW-1:0] SPAN_VIOLET = DW'(60 << ftr_pkg::WL_FRAC);
    localparam logic [DW-1:0] SPAN_BLUE   = DW'(50 << ftr_pkg::WL_FRAC);
    localparam logic [DW-1:0] SPAN_CYAN   = DW'(20 << ftr_pkg::WL_FRAC);
    localparam logic [DW-1:0] SPAN_GREEN  = DW'(70 << ftr_pkg::WL_FRAC);
    localparam logic [DW-1:0] SPAN_YELLOW = DW'(65 << ftr_pkg::WL_FRAC);
    localparam logic [DW-1:0] SPAN_UNIT   = DW'(1);

    logic [CW-1:0]   wl;
    logic [SW-1:0]   wl_s;
    ftr_pkg::band_t  band;
    logic [SW-1:0]   dist_w;
    logic [DW-1:0]   span;

    logic            s1_valid_reg;
    ftr_pkg::tag_t   s1_tag_reg;
    logic [DW-1:0]   s1_dist_reg;
    logic [DW-1:0]   s1_span_reg;

    logic            s2_valid_reg;
    ftr_pkg::tag_t   s2_tag_reg;
    logic [PW-1:0]   s2_prod_reg;
    logic [DW-1:0]   s2_span_reg;
    logic [PW-1:0]   prod_next;

    // band lookup
    always_comb begin
        wl   = wl_in.quo;
        wl_s = wl[SW-1:0];
        band   = ftr_pkg::BAND_NONE;
        dist_w = '0;
        span   = SPAN_UNIT;
        if (wl_in.tag.zero || wl < WL_380 || wl >= WL_781) begin
            band = ftr_pkg::BAND_NONE;
        end else if (wl < WL_440) begin
            band   = ftr_pkg::BAND_VIOLET;
            dist_w = S_440 - wl_s;
            span   = SPAN_VIOLET;
        end else if (wl < WL_490) begin
            band   = ftr_pkg::BAND_BLUE;
            dist_w = wl_s - S_440;
            span   = SPAN_BLUE;
        end else if (wl < WL_510) begin
            band   = ftr_pkg::BAND_CYAN;
            dist_w = S_510 - wl_s;
            span   = SPAN_CYAN;
        end else if (wl < WL_580) begin
            band   = ftr_pkg::BAND_GREEN;
            dist_w = wl_s - S_510;
            span   = SPAN_GREEN;
        end else if (wl < WL_645) begin
            band   = ftr_pkg::BAND_YELLOW;
            dist_w = S_645 - wl_s;
            span   = SPAN_YELLOW;
        end else begin
            band = ftr_pkg::BAND_RED;
        end
    end

    // control of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= wl_in.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // ramp product
    assign prod_next = PW'(max_level) * PW'(s1_dist_reg);

    // payload of both stages
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tag_reg  <= '{zero: wl_in.tag.zero, band: band};
            s1_dist_reg <= dist_w[DW-1:0];
            s1_span_reg <= span;
            s2_tag_reg  <= s1_tag_reg;
            s2_prod_reg <= prod_next;
            s2_span_reg <= s1_span_reg;
        end
    end

    // dividend at the top of the quotient register
    assign ramp_out = '{valid: s2_valid_reg,
                        tag:   s2_tag_reg,
                        rem:   '0,
                        dvs:   FW'(s2_span_reg),
                        quo:   {s2_prod_reg, (CW - PW)'(0)}};

endmodule
